[hdl/b64lw_pkg.sv]
// Shared types, constants and the alphabet function of the line-wrapped base64 encoder.
package b64lw_pkg;

   localparam int LINE_CHARS      = 76;
   localparam int GROUPS_PER_LINE = ((LINE_CHARS / 4) > 0) ? (LINE_CHARS / 4) : 1;
   localparam int GIL_W           = $clog2(GROUPS_PER_LINE + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PAD     = 8'h3D;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;

   // Positions of the characters that one group can produce.
   localparam logic [2:0] SLOT_FIRST  = 3'd0;
   localparam logic [2:0] SLOT_SECOND = 3'd1;
   localparam logic [2:0] SLOT_THIRD  = 3'd2;
   localparam logic [2:0] SLOT_FOURTH = 3'd3;
   localparam logic [2:0] SLOT_CR     = 3'd4;
   localparam logic [2:0] SLOT_LF     = 3'd5;

   // How many message bytes the group carries.
   typedef enum logic [1:0] {
      KIND_ONE  = 2'd0,
      KIND_TWO  = 2'd1,
      KIND_FULL = 2'd2
   } kind_type;

   typedef struct packed {
      logic [23:0] word;
      kind_type    kind;
      logic        crlf;
      logic        last;
   } cmd_type;

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] v8;
      logic [7:0] c;
      v8 = {2'b00, v};
      if (v < 6'd26) begin
         c = CHAR_UPPER_A + v8;
      end else if (v < 6'd52) begin
         c = CHAR_LOWER_A + (v8 - 8'd26);
      end else if (v < 6'd62) begin
         c = CHAR_DIGIT_0 + (v8 - 8'd52);
      end else if (v == 6'd62) begin
         c = CHAR_PLUS;
      end else begin
         c = CHAR_SLASH;
      end
      return c;
   endfunction

endpackage

[hdl/b64lw_front.sv]
// Front end: collects input bytes into groups and decides padding and line ends.
module b64lw_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wen,
   input  logic               csr_wdata,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   input  logic               q_full,
   output logic               q_push,
   output b64lw_pkg::cmd_type q_cmd
);
   import b64lw_pkg::*;

   logic             multi_line_ff, multi_line_in;
   logic [7:0]       held_ff [2];
   logic [1:0]       fill_ff, fill_in;
   logic [GIL_W-1:0] gil_ff, gil_in;
   logic [GIL_W-1:0] gil_inc;
   logic             accept;
   logic             line_end;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept && (fill_ff[1] || req_tlast);
   assign gil_inc    = gil_ff + GIL_W'(1);
   assign line_end   = (gil_inc >= GIL_W'(GROUPS_PER_LINE));

   always_comb begin
      q_cmd      = '0;
      q_cmd.last = req_tlast;
      unique case (fill_ff)
         2'd2: begin
            q_cmd.word = {held_ff[0], held_ff[1], req_tdata};
            q_cmd.kind = KIND_FULL;
            q_cmd.crlf = line_end && multi_line_ff;
         end
         2'd1: begin
            q_cmd.word = {held_ff[0], req_tdata, 8'h00};
            q_cmd.kind = KIND_TWO;
         end
         default: begin
            q_cmd.word = {req_tdata, 16'h0000};
            q_cmd.kind = KIND_ONE;
         end
      endcase
   end

   always_comb begin
      multi_line_in = csr_wen ? csr_wdata : multi_line_ff;
      fill_in       = fill_ff;
      gil_in        = gil_ff;
      if (q_push) begin
         fill_in = 2'd0;
         if (fill_ff[1]) begin
            gil_in = line_end ? '0 : gil_inc;
         end
         // The line count restarts with every message.
         if (req_tlast) begin
            gil_in = '0;
         end
      end else if (accept) begin
         fill_in = fill_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         multi_line_ff <= 1'b0;
         fill_ff       <= 2'd0;
         gil_ff        <= '0;
      end else begin
         multi_line_ff <= multi_line_in;
         fill_ff       <= fill_in;
         gil_ff        <= gil_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !q_push) begin
         held_ff[fill_ff[0]] <= req_tdata;
      end
   end

endmodule

[hdl/b64lw_queue.sv]
// Short queue of group commands between the front and the back end.
module b64lw_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  b64lw_pkg::cmd_type push_cmd,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output b64lw_pkg::cmd_type head_cmd
);
   import b64lw_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from an empty queue");

endmodule

[hdl/b64lw_back.sv]
// Back end: puts each group's characters in an output register, one per cycle unless stalled.
module b64lw_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  b64lw_pkg::cmd_type q_cmd,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast
);
   import b64lw_pkg::*;

   cmd_type    cmd_ff;
   logic       busy_ff, busy_in;
   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff;
   logic       rsp_last_ff;
   logic       out_free;
   logic       emit;
   logic       is_final;
   logic [2:0] final_idx;
   logic [7:0] char_now;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit      = busy_ff && out_free;
   assign final_idx = cmd_ff.crlf ? SLOT_LF : SLOT_FOURTH;
   assign is_final  = (idx_ff == final_idx);
   // The next group is taken at the same edge that sends the last character of this one.
   assign q_pop     = q_valid && (!busy_ff || (emit && is_final));

   always_comb begin
      char_now = CHAR_PAD;
      unique case (idx_ff)
         SLOT_FIRST: char_now = b64_char(cmd_ff.word[23:18]);
         SLOT_SECOND: char_now = b64_char(cmd_ff.word[17:12]);
         SLOT_THIRD: char_now = (cmd_ff.kind == KIND_ONE) ? CHAR_PAD
                                                          : b64_char(cmd_ff.word[11:6]);
         SLOT_FOURTH: char_now = (cmd_ff.kind == KIND_FULL) ? b64_char(cmd_ff.word[5:0])
                                                            : CHAR_PAD;
         SLOT_CR:    char_now = CHAR_CR;
         SLOT_LF:    char_now = CHAR_LF;
         default:    char_now = CHAR_PAD;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         idx_in  = SLOT_FIRST;
      end else if (emit && is_final) begin
         busy_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 3'd1;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= SLOT_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_cmd;
      end
      if (emit) begin
         rsp_data_ff <= char_now;
         rsp_last_ff <= cmd_ff.last && is_final;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= SLOT_LF))
      else $error("character index beyond line end");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && rsp_valid_ff && !rsp_tready) |=> (busy_ff && $stable(idx_ff)))
      else $error("character sequence advanced during output stall");

   a_cr_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff == CHAR_CR) |-> !rsp_last_ff)
      else $error("end of message marked on a carriage return");

endmodule

[hdl/base64_line_wrapped_encoder_top.sv]
// Top level of the base64 encoder with optional CR LF line wrapping.
// Bytes arrive one word per cycle on the req_ channel while req_tready is high, tlast on the
// final byte of a message; base64 characters leave one word per cycle on the rsp_ channel while
// rsp_tready is high, tlast on the final character. The front end takes a byte in every cycle
// while its two-entry group queue has room, so the sustained rate is set by the
// single-character output register: a group of three bytes yields four characters, six when it
// ends a line in multi-line mode. Groups go via the queue, command and output registers.
// csr_wdata sets multi-line mode (reset off); write it only while no message is in flight.
module base64_line_wrapped_encoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wen,
   input  logic       csr_wdata,   // multi_line
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast    // out_last
);
   import b64lw_pkg::*;

   logic    q_full;
   logic    q_push;
   cmd_type q_push_cmd;
   logic    q_pop;
   logic    q_head_valid;
   cmd_type q_head_cmd;

   b64lw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_push_cmd)
   );

   b64lw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_cmd   (q_head_cmd)
   );

   b64lw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_head_valid),
      .q_cmd      (q_head_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
